/* hdl/lru_key_value_cache_top_defines.svh */
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define LKVC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("lkvc assertion failed");

// Consequent that must hold in the same cycle as the antecedent.
`define LKVC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lkvc implication failed");

`endif

/* hdl/lkvc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int WIDE_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef word_t [ENTRIES-1:0] word_arr_t;
  typedef rank_t [ENTRIES-1:0] rank_arr_t;

  localparam word_t MISS_VALUE = '1;

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_SET = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] lookup_key;
    logic signed [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
    logic               evicted;
  } out_item_t;

  typedef struct packed {
    logic               en;
    logic [ENTRIES-1:0] valid;
    rank_arr_t          ranks;
    logic [CNT_W-1:0]   occ;
    logic [ENTRIES-1:0] key_we;
    logic [ENTRIES-1:0] val_we;
    word_t              key;
    word_t              value;
  } upd_t;

endpackage

`default_nettype wire

/* hdl/lru_key_value_cache_top.sv */
// Fully associative LRU key-value cache, one access per transaction.
// A transaction accepted on start is registered into in_r, looked up
// combinationally, and its result is registered into out_r with out_strobe.
// Throughput: one transaction per cycle; busy stays low and nothing stalls.
// Reset (rst_n low, synchronous) empties the cache and sets capacity to 16.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_key_value_cache_top_defines.svh"

module lru_key_value_cache_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire lkvc_pkg::in_item_t          in_data,
  output logic                             out_strobe,
  output lkvc_pkg::out_item_t              out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [lkvc_pkg::CAP_W-1:0]  cfg_data
);

  logic                          in_vld_r;
  lkvc_pkg::in_item_t            in_r;
  logic [lkvc_pkg::CAP_W-1:0]    cap_r;
  logic                          out_strobe_r;
  lkvc_pkg::out_item_t           out_r;

  lkvc_pkg::upd_t                upd;
  lkvc_pkg::out_item_t           result;
  lkvc_pkg::word_arr_t           st_keys;
  lkvc_pkg::word_arr_t           st_values;
  logic [lkvc_pkg::ENTRIES-1:0]  st_valid;
  lkvc_pkg::rank_arr_t           st_ranks;
  logic [lkvc_pkg::CNT_W-1:0]    st_occ;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      cap_r        <= lkvc_pkg::CAP_RESET;
    end else begin
      in_vld_r     <= start && !busy;
      out_strobe_r <= in_vld_r;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
    if (in_vld_r) begin
      out_r <= result;
    end
  end

  lkvc_engine u_engine (
    .vld      (in_vld_r),
    .item     (in_r),
    .capacity (cap_r),
    .keys     (st_keys),
    .values   (st_values),
    .valid    (st_valid),
    .ranks    (st_ranks),
    .occ      (st_occ),
    .upd      (upd),
    .result   (result)
  );

  lkvc_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (upd),
    .keys   (st_keys),
    .values (st_values),
    .valid  (st_valid),
    .ranks  (st_ranks),
    .occ    (st_occ)
  );

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  `LKVC_ASSERT_ALWAYS(a_occ_matches_valid, clk, rst_n, $countones(st_valid) == int'(st_occ))
  `LKVC_ASSERT_ALWAYS(a_occ_bound, clk, rst_n, int'(st_occ) <= lkvc_pkg::ENTRIES)
  `LKVC_ASSERT_IMPLY(a_evict_is_set_miss, clk, rst_n,
                     out_strobe && out_data.evicted,
                     !out_data.found && (out_data.read_value == lkvc_pkg::MISS_VALUE))

endmodule

`default_nettype wire

/* hdl/lkvc_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module lkvc_store (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lkvc_pkg::upd_t              upd,
  output lkvc_pkg::word_arr_t              keys,
  output lkvc_pkg::word_arr_t              values,
  output logic [lkvc_pkg::ENTRIES-1:0]     valid,
  output lkvc_pkg::rank_arr_t              ranks,
  output logic [lkvc_pkg::CNT_W-1:0]       occ
);

  lkvc_pkg::word_arr_t              keys_r;
  lkvc_pkg::word_arr_t              values_r;
  logic [lkvc_pkg::ENTRIES-1:0]     valid_r;
  lkvc_pkg::rank_arr_t              ranks_r;
  logic [lkvc_pkg::CNT_W-1:0]       occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ranks_r <= '0;
      occ_r   <= '0;
    end else if (upd.en) begin
      valid_r <= upd.valid;
      ranks_r <= upd.ranks;
      occ_r   <= upd.occ;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (upd.key_we[i]) begin
        keys_r[i] <= upd.key;
      end
      if (upd.val_we[i]) begin
        values_r[i] <= upd.value;
      end
    end
  end

  assign keys   = keys_r;
  assign values = values_r;
  assign valid  = valid_r;
  assign ranks  = ranks_r;
  assign occ    = occ_r;

endmodule

`default_nettype wire

/* hdl/lkvc_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

module lkvc_engine (
  input  wire logic                          vld,
  input  wire lkvc_pkg::in_item_t            item,
  input  wire logic [lkvc_pkg::CAP_W-1:0]    capacity,
  input  wire lkvc_pkg::word_arr_t           keys,
  input  wire lkvc_pkg::word_arr_t           values,
  input  wire logic [lkvc_pkg::ENTRIES-1:0]  valid,
  input  wire lkvc_pkg::rank_arr_t           ranks,
  input  wire logic [lkvc_pkg::CNT_W-1:0]    occ,
  output lkvc_pkg::upd_t                     upd,
  output lkvc_pkg::out_item_t                result
);

  logic [lkvc_pkg::ENTRIES-1:0] match;
  logic [lkvc_pkg::ENTRIES-1:0] lru_oh;
  logic [lkvc_pkg::ENTRIES-1:0] evict_oh;
  logic [lkvc_pkg::ENTRIES-1:0] keep;
  logic [lkvc_pkg::ENTRIES-1:0] free_inv;
  logic [lkvc_pkg::ENTRIES-1:0] slot_oh;
  logic [lkvc_pkg::ENTRIES-1:0] ins_oh;
  logic                         hit;
  logic                         is_set;
  logic                         do_evict;
  logic                         ins;
  lkvc_pkg::word_t              hit_val;
  lkvc_pkg::rank_t              hit_rank;
  lkvc_pkg::rank_t              lru_rank;
  logic [lkvc_pkg::WIDE_W-1:0]  cap_w;
  logic [lkvc_pkg::WIDE_W-1:0]  eff_cap;
  logic [lkvc_pkg::WIDE_W-1:0]  occ_w;

  always_comb begin
    is_set   = (item.mode == lkvc_pkg::MODE_SET);
    hit_val  = '0;
    hit_rank = '0;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      match[i] = valid[i] && (keys[i] == lkvc_pkg::word_t'(item.lookup_key));
      hit_val  = hit_val | (match[i] ? values[i] : '0);
      hit_rank = hit_rank | (match[i] ? ranks[i] : '0);
    end
    hit = |match;

    cap_w = lkvc_pkg::WIDE_W'(capacity);
    occ_w = lkvc_pkg::WIDE_W'(occ);
    if (cap_w == '0) begin
      eff_cap = lkvc_pkg::WIDE_W'(1);
    end else if (cap_w > lkvc_pkg::WIDE_W'(lkvc_pkg::ENTRIES)) begin
      eff_cap = lkvc_pkg::WIDE_W'(lkvc_pkg::ENTRIES);
    end else begin
      eff_cap = cap_w;
    end

    // Valid entries hold distinct ranks, so the oldest one has rank occupancy - 1.
    lru_rank = lkvc_pkg::RANK_W'(occ - lkvc_pkg::CNT_W'(1));
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      lru_oh[i] = valid[i] && (ranks[i] == lru_rank);
    end

    do_evict = vld && is_set && !hit && (occ_w >= eff_cap) && (occ != '0);
    evict_oh = do_evict ? lru_oh : '0;
    keep     = valid & ~evict_oh;
    free_inv = ~keep;
    slot_oh  = free_inv & (~free_inv + lkvc_pkg::ENTRIES'(1));
    ins      = vld && is_set && !hit && (|slot_oh);
    ins_oh   = ins ? slot_oh : '0;

    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      upd.ranks[i] = ranks[i];
      if (vld && hit) begin
        if (match[i]) begin
          upd.ranks[i] = '0;
        end else if (valid[i] && (ranks[i] < hit_rank)) begin
          upd.ranks[i] = ranks[i] + lkvc_pkg::RANK_W'(1);
        end
      end else if (ins) begin
        if (ins_oh[i]) begin
          upd.ranks[i] = '0;
        end else if (keep[i]) begin
          upd.ranks[i] = ranks[i] + lkvc_pkg::RANK_W'(1);
        end
      end
    end

    upd.en     = vld;
    upd.valid  = keep | ins_oh;
    upd.occ    = occ - lkvc_pkg::CNT_W'(do_evict) + lkvc_pkg::CNT_W'(ins);
    upd.key_we = ins_oh;
    upd.val_we = ins_oh | ((vld && is_set && hit) ? match : '0);
    upd.key    = lkvc_pkg::word_t'(item.lookup_key);
    upd.value  = lkvc_pkg::word_t'(item.write_value);

    result.found      = hit;
    result.read_value = (!is_set && hit) ? hit_val : lkvc_pkg::MISS_VALUE;
    result.evicted    = do_evict;
  end

endmodule

`default_nettype wire

/* tb/sv/lru_key_value_cache_top_tb.sv */
`timescale 1ns / 1ps

module lru_key_value_cache_top_tb;
  import lkvc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ACCESSES = 85;
  localparam int POOL_SIZE = 24;

  typedef struct {
    bit          is_cfg;
    logic [4:0]  cap;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_strobe;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  bit          item_typed = 1'b0;
  out_item_t   item_want = '0;

  word_t       model_key [ENTRIES];
  word_t       model_val [ENTRIES];
  bit          model_valid [ENTRIES];
  int unsigned model_rank [ENTRIES];
  int unsigned model_occ;
  logic [CAP_W-1:0] model_cap;

  out_item_t   pending_results[$];
  int          errors = 0;
  int          cycle_count = 0;
  int          accesses = 0;
  int          hits = 0;
  int          evictions = 0;
  int          cap_writes = 0;

  lru_key_value_cache_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic int effective_capacity(logic [CAP_W-1:0] cap);
    int eff;
    eff = cap;
    if (eff < 1) eff = 1;
    if (eff > ENTRIES) eff = ENTRIES;
    return eff;
  endfunction

  // Applies one access to the shadow cache and returns the result it must produce.
  function automatic out_item_t cache_access(in_item_t it);
    out_item_t   r;
    int          hit;
    int          lru;
    int          slot;
    int          i;
    int unsigned old_rank;
    hit = -1;
    lru = -1;
    slot = -1;
    r.found = 1'b0;
    r.read_value = MISS_VALUE;
    r.evicted = 1'b0;
    for (i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && model_valid[i] && model_key[i] == it.lookup_key) hit = i;
    end
    if (hit >= 0) begin
      r.found = 1'b1;
      if (it.mode == MODE_GET) r.read_value = model_val[hit];
      else model_val[hit] = it.write_value;
      old_rank = model_rank[hit];
      for (i = 0; i < ENTRIES; i++) begin
        if (model_valid[i] && model_rank[i] < old_rank) model_rank[i]++;
      end
      model_rank[hit] = 0;
    end else if (it.mode == MODE_SET) begin
      if (model_occ >= effective_capacity(model_cap) && model_occ > 0) begin
        for (i = 0; i < ENTRIES; i++) begin
          if (model_valid[i] && (lru < 0 || model_rank[i] > model_rank[lru])) lru = i;
        end
        if (lru >= 0) begin
          model_valid[lru] = 1'b0;
          model_occ--;
          r.evicted = 1'b1;
        end
      end
      for (i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && !model_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        for (i = 0; i < ENTRIES; i++) begin
          if (model_valid[i]) model_rank[i]++;
        end
        model_valid[slot] = 1'b1;
        model_key[slot] = it.lookup_key;
        model_val[slot] = it.write_value;
        model_rank[slot] = 0;
        model_occ++;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t predicted;
    out_item_t want;
    int        i;
    if (!rst_n) begin
      for (i = 0; i < ENTRIES; i++) begin
        model_valid[i] = 1'b0;
        model_rank[i] = 0;
      end
      model_occ = 0;
      model_cap = CAP_RESET;
      pending_results.delete();
    end else begin
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: found %0d read_value %h evicted %0d",
                   $time, out_data.found, out_data.read_value, out_data.evicted);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.found !== want.found) begin
            $display("%0t: found mismatch: expected %0d actual %0d",
                     $time, want.found, out_data.found);
            errors++;
          end
          if (out_data.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch: expected %h actual %h",
                     $time, want.read_value, out_data.read_value);
            errors++;
          end
          if (out_data.evicted !== want.evicted) begin
            $display("%0t: evicted mismatch: expected %0d actual %0d",
                     $time, want.evicted, out_data.evicted);
            errors++;
          end
          if (want.found) hits++;
          if (want.evicted) evictions++;
        end
      end
      if (cfg_valid && cfg_ready) model_cap = cfg_data;
      if (start && !busy) begin
        predicted = cache_access(in_data);
        pending_results.push_back(item_typed ? item_want : predicted);
        accesses++;
      end
    end
  end

  task automatic send_access(in_item_t it, bit typed, out_item_t want);
    in_data <= it;
    item_typed <= typed;
    item_want <= want;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  function automatic script_row_t access_row(mode_t m, word_t key, word_t value, bit typed,
                                             bit found, word_t rd, bit ev);
    script_row_t row;
    row.is_cfg = 1'b0;
    row.cap = '0;
    row.item.mode = m;
    row.item.lookup_key = key;
    row.item.write_value = value;
    row.typed = typed;
    row.want.found = found;
    row.want.read_value = rd;
    row.want.evicted = ev;
    return row;
  endfunction

  function automatic script_row_t cap_row(logic [CAP_W-1:0] cap);
    script_row_t row;
    row = access_row(MODE_GET, '0, '0, 1'b0, 1'b0, '0, 1'b0);
    row.is_cfg = 1'b1;
    row.cap = cap;
    return row;
  endfunction

  initial begin : timeout
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("lru_key_value_cache_top verification failed");
    $finish;
  end

  initial begin : stimulus
    script_row_t script[$];
    word_t       key_pool [POOL_SIZE];
    int          caps [9];
    in_item_t    it;
    int          p;
    int          n;
    int          k;
    int          span;
    int          gap_max;
    int          gap;
    int          burst;

    caps = '{16, 0, 31, 1, 2, 17, 4, 8, 15};
    script = '{
      access_row(MODE_GET, 32'h0000_0000, 32'h0000_0000, 1, 0, MISS_VALUE, 0),
      access_row(MODE_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, MISS_VALUE, 0),
      access_row(MODE_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, MISS_VALUE, 0),
      access_row(MODE_GET, 32'h8000_0000, 32'h1234_5678, 1, 1, 32'h7FFF_FFFF, 0),
      access_row(MODE_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, 32'h8000_0000, 0),
      access_row(MODE_SET, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1, MISS_VALUE, 0),
      access_row(MODE_GET, 32'h8000_0000, 32'h0000_0000, 1, 1, 32'hFFFF_FFFF, 0),
      access_row(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1, 0, MISS_VALUE, 0),
      access_row(MODE_SET, 32'hFFFF_FFFF, 32'h0000_0000, 1, 0, MISS_VALUE, 0),
      access_row(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1, 32'h0000_0000, 0),
      cap_row(5'd0),
      access_row(MODE_SET, 32'h0000_0005, 32'h0000_0005, 1, 0, MISS_VALUE, 1),
      access_row(MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1, 0, MISS_VALUE, 0),
      access_row(MODE_SET, 32'h0000_0006, 32'h0000_0006, 1, 0, MISS_VALUE, 1),
      access_row(MODE_GET, 32'h8000_0000, 32'h0000_0000, 1, 0, MISS_VALUE, 0),
      access_row(MODE_SET, 32'hFFFF_FFFF, 32'h0000_0001, 1, 1, MISS_VALUE, 0),
      cap_row(5'd31),
      access_row(MODE_SET, 32'h0000_0007, 32'h0000_0007, 1, 0, MISS_VALUE, 0),
      access_row(MODE_GET, 32'h0000_0005, 32'h0000_0000, 1, 1, 32'h0000_0005, 0),
      cap_row(5'd16),
      access_row(MODE_SET, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0, '0, 0),
      access_row(MODE_GET, 32'h5555_5555, 32'h0000_0000, 0, 0, '0, 0),
      cap_row(5'd1),
      access_row(MODE_SET, 32'hAAAA_AAAA, 32'h5555_5555, 0, 0, '0, 0),
      access_row(MODE_GET, 32'h5555_5555, 32'hFFFF_FFFF, 0, 0, '0, 0)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[s]) begin
      if (script[s].is_cfg) set_capacity(script[s].cap);
      else send_access(script[s].item, script[s].typed, script[s].want);
    end

    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 9) set_capacity(CAP_W'(caps[p]));
      else set_capacity(CAP_W'($urandom_range(0, 31)));
      for (k = 0; k < POOL_SIZE; k++) key_pool[k] = $urandom;
      if (p == 0) begin
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
      end
      span = effective_capacity(model_cap) + $urandom_range(0, 6);
      if (span > POOL_SIZE - 1) span = POOL_SIZE - 1;
      gap_max = (p % 3 == 1) ? 0 : $urandom_range(1, 6);
      burst = 0;
      for (n = 0; n < PHASE_ACCESSES; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 16);
          gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
          if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        it.mode = mode_t'($urandom_range(0, 1));
        it.lookup_key = ($urandom_range(0, 9) == 0) ? $urandom
                                                    : key_pool[$urandom_range(0, span)];
        it.write_value = $urandom;
        send_access(it, 1'b0, '0);
        burst--;
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (pending_results.size() != 0 || out_strobe) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Ran %0d cache accesses (%0d hits, %0d evictions) across %0d capacity writes.",
             accesses, hits, evictions, cap_writes);
    $display("Directed corner cases came first, then random get/set traffic on small key pools.");
    if (errors == 0) begin
      $display("lru_key_value_cache_top verification clean");
    end else begin
      $display("lru_key_value_cache_top verification failed");
    end
    $finish;
  end

endmodule
